// ===== src/i2c_bus_recovery_sequencer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// i2c bus recovery sequencer assertion macros
// shared concurrent assertion wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef I2C_BUS_RECOVERY_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_BUS_RECOVERY_SEQUENCER_UNIT_DEFINES_SVH

// clocked assertion, quiet while reset is high
`define BRS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define BRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/brs_pkg.sv =====
// ----------------------------------------------------------------------------
// brs_pkg
// shared types and constants of the i2c bus recovery sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brs_pkg;

  localparam int COUNT_BITS = 16;
  localparam int HOLD_BITS  = 16;
  localparam int PULSE_BITS = 4;

  localparam logic [PULSE_BITS-1:0] MAX_PULSES = PULSE_BITS'(9);
  localparam logic [PULSE_BITS-1:0] PULSE_SAT  = '1;
  localparam logic [COUNT_BITS-1:0] ELAPSED_SAT = '1;
  localparam logic [HOLD_BITS-1:0]  HOLD_RESET = HOLD_BITS'(100);

  // register index as decoded from paddr[2]
  localparam logic REG_HOLD_TIME = 1'b0;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_CLEAR = 2'd1,
    PH_HOLD  = 2'd2
  } phase_t;

  // one result item, scl_drive_low in bit 0
  typedef struct packed {
    logic                  recovery_done;
    logic [PULSE_BITS-1:0] pulses_given;
    logic [1:0]            phase;
    logic                  controller_enabled;
    logic                  scl_drive_low;
  } result_t;

endpackage

// ===== src/i2c_bus_recovery_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_bus_recovery_sequencer_unit
// i2c bus-clear recovery sequencer, advanced once per millisecond tick
// ----------------------------------------------------------------------------
// usage
//   s_* stream: one transfer per millisecond tick, carrying the restart
//   request and the sampled sda level
//   m_* stream: one result transfer per tick with the scl drive, controller
//   enable, phase, pulse count and a done flag for the tick that ends recovery
//   apb port: hold_time at byte address 0, read back the same way
// timing
//   a tick updates the sequencer state in the cycle it is taken; its result
//   is registered in the output register, or in the skid entry while the consumer stalls
//   one tick per cycle sustained; the output register plus a single skid
//   entry keep s_tready high while the consumer takes results
// stall
//   a stalled consumer fills the skid entry, then s_tready drops until the
//   output register drains; no result is lost or repeated
// reset
//   rst is synchronous: phase idle, scl released, counters zero, hold_time
//   back to 100 and both stream stages empty
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_bus_recovery_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  // bit 0 restart_request, bit 1 sda_level, rest zero
  input  logic [7:0]  s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // bit 0 scl_drive_low, 1 controller_enabled, 3:2 phase, 7:4 pulses_given,
  // 8 recovery_done, rest zero
  output logic [15:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import brs_pkg::*;

  logic [HOLD_BITS-1:0] hold_time;
  logic                 accept;
  result_t              core_result;
  result_t              out_result;

  // tick transfer completes here
  assign accept = s_tvalid && s_tready;

  brs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .hold_time (hold_time)
  );

  // state registers and next-state logic
  brs_core u_core (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .restart_request (s_tdata[0]),
    .sda_level       (s_tdata[1]),
    .hold_time       (hold_time),
    .result          (core_result)
  );

  // result register, decouples s_tready from m_tready
  brs_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (core_result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  assign m_tdata = {(16 - $bits(result_t))'(0), out_result};

endmodule

// ===== src/brs_cfg.sv =====
// ----------------------------------------------------------------------------
// brs_cfg
// apb register file holding the hold time
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brs_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [brs_pkg::HOLD_BITS-1:0] hold_time
);
  import brs_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_HOLD_TIME);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time <= HOLD_RESET;
    end else if (wr_en) begin
      hold_time <= pwdata[HOLD_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_HOLD_TIME) begin
      prdata = 32'(hold_time);
    end
  end

endmodule

// ===== src/brs_core.sv =====
// ----------------------------------------------------------------------------
// brs_core
// per-tick recovery state update and result forming
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brs_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          restart_request,
  input  logic                          sda_level,
  input  logic [brs_pkg::HOLD_BITS-1:0] hold_time,
  output brs_pkg::result_t              result
);
  import brs_pkg::*;

  phase_t                phase, phase_next;
  logic                  scl_low, scl_low_next;
  logic [PULSE_BITS-1:0] pulse_count, pulse_count_next;
  logic [COUNT_BITS-1:0] elapsed, elapsed_next;
  logic [COUNT_BITS-1:0] elapsed_inc;
  logic                  done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      scl_low     <= 1'b0;
      pulse_count <= '0;
      elapsed     <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      scl_low     <= scl_low_next;
      pulse_count <= pulse_count_next;
      elapsed     <= elapsed_next;
    end
  end

  // saturating tick counter
  assign elapsed_inc = (elapsed == ELAPSED_SAT) ? elapsed : elapsed + COUNT_BITS'(1);

  always_comb begin
    phase_next       = phase;
    scl_low_next     = scl_low;
    pulse_count_next = pulse_count;
    elapsed_next     = elapsed;
    done             = 1'b0;
    case (phase)
      PH_CLEAR: begin
        elapsed_next = elapsed_inc;
        if (scl_low) begin
          scl_low_next = 1'b0;
          if (pulse_count != PULSE_SAT) begin
            pulse_count_next = pulse_count + PULSE_BITS'(1);
          end
        end else if (sda_level || (pulse_count >= MAX_PULSES)) begin
          phase_next = PH_HOLD;
        end else begin
          scl_low_next = 1'b1;
        end
      end
      PH_HOLD: begin
        elapsed_next = elapsed_inc;
        if ((elapsed_inc >= hold_time) || (elapsed_inc == ELAPSED_SAT)) begin
          phase_next   = PH_IDLE;
          scl_low_next = 1'b0;
          done         = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (restart_request) begin
          phase_next       = PH_CLEAR;
          elapsed_next     = '0;
          pulse_count_next = '0;
          scl_low_next     = 1'b0;
        end
      end
    endcase
  end

  always_comb begin
    result.scl_drive_low      = scl_low_next;
    result.controller_enabled = (phase_next == PH_IDLE);
    result.phase              = phase_next;
    result.pulses_given       = pulse_count_next;
    result.recovery_done      = done;
  end

endmodule

// ===== src/brs_skid.sv =====
// ----------------------------------------------------------------------------
// brs_skid
// result register with one skid entry between core and output stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brs_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  brs_pkg::result_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output brs_pkg::result_t out_data
);
  import brs_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    load_main;

  assign in_ready  = !skid_valid;
  assign load_main = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_main) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_main) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid && in_ready) begin
      skid_data <= in_data;
    end
  end

endmodule

// ===== src/brs_checker.sv =====
// ----------------------------------------------------------------------------
// brs_checker
// port-level checks of the i2c bus recovery sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_bus_recovery_sequencer_unit_defines.svh"

module brs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic [15:0] m_tdata,
  input logic        m_tvalid,
  input logic        m_tready
);
  import brs_pkg::*;

  logic                  m_scl_low;
  logic                  m_enable;
  logic [1:0]            m_phase;
  logic [PULSE_BITS-1:0] m_pulses;
  logic                  m_done;

  assign m_scl_low = m_tdata[0];
  assign m_enable  = m_tdata[1];
  assign m_phase   = m_tdata[3:2];
  assign m_pulses  = m_tdata[7:4];
  assign m_done    = m_tdata[8];

  // stalled result holds
  `BRS_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stall")

  // input back-pressure only with a result pending
  `BRS_ASSERT(a_ready_back, clk, rst, !s_tready |-> m_tvalid, "s_tready low with empty output")

  // controller owns the pins exactly in idle
  `BRS_ASSERT(a_enable_phase, clk, rst, m_tvalid |-> (m_enable == (m_phase == PH_IDLE)), "enable")

  // done only on return to idle with scl released, pulse count in range
  `BRS_ASSERT(a_done_idle, clk, rst, m_tvalid && m_done |-> (m_phase == PH_IDLE) && !m_scl_low && (m_pulses <= MAX_PULSES), "done")

  // result stream starts empty after reset
  `BRS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "result present after reset")

endmodule

bind i2c_bus_recovery_sequencer_unit brs_checker u_brs_checker (.*);
